// ===== rtl/lzbw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lzbw_pkg;

    // Window and token geometry
    localparam int WINDOW_BITS = 8;
    localparam int LENGTH_BITS = 4;
    localparam int WIN_DEPTH   = 1 << WINDOW_BITS;
    localparam int BYTE_W      = 8;
    localparam int SH_W        = $clog2(BYTE_W);
    localparam int LEN_CFG_W   = 24;
    localparam int LIT_BITS    = 1 + BYTE_W;
    localparam int MATCH_BITS  = 1 + WINDOW_BITS + LENGTH_BITS;
    localparam int TOK_W       = MATCH_BITS;
    localparam int CNT_W       = $clog2(TOK_W + 1);
    localparam int MAX_COPY    = (1 << LENGTH_BITS) + 1;
    localparam int COPY_W      = $clog2(MAX_COPY + 2);
    localparam int WP_RESET    = WIN_DEPTH - MAX_COPY;

    typedef logic [WINDOW_BITS-1:0] win_addr_t;
    typedef logic [BYTE_W-1:0]      byte_t;

    // History memory request from the decode core
    typedef struct packed {
        logic      clear;
        logic      we;
        win_addr_t waddr;
        byte_t     wdata;
        logic      re;
        win_addr_t raddr;
    } hm_req_t;

    // Core status seen by the top level
    typedef struct packed {
        logic              copying;
        logic [COPY_W-1:0] copy_left;
    } core_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lzbw_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lzbw_in_if;
    import lzbw_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzbw_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lzbw_out_if;
    import lzbw_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_done;

    modport source (output valid, output out_byte, output last_of_run, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input stream_done,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lzbw_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lzbw_cfg_if;
    import lzbw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LEN_CFG_W-1:0] output_length;

    modport source (output valid, output output_length, input ready);
    modport sink   (input valid, input output_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzbw_hist_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzbw_hist_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  lzbw_pkg::hm_req_t req,
    output lzbw_pkg::byte_t   rdata
);
    import lzbw_pkg::*;

    byte_t                ram [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] valid_reg;
    byte_t                ram_q_reg;
    byte_t                byp_data_reg;
    logic                 byp_reg;
    logic                 hit_reg;

    // Storage array, read-old on a same-address write
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            ram[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            ram_q_reg    <= ram[req.raddr];
            byp_data_reg <= req.wdata;
        end
    end

    // Per-entry written marks; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            byp_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                // forward the byte written in the read cycle
                byp_reg <= req.we && (req.waddr == req.raddr);
                hit_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = byp_reg ? byp_data_reg : (hit_reg ? ram_q_reg : '0);

endmodule

`default_nettype wire

// ===== rtl/lzbw_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzbw_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lzbw_pkg::LEN_CFG_W-1:0] output_length,
    lzbw_in_if.sink                        comp_bytes,
    lzbw_out_if.source                     plain_bytes,
    output lzbw_pkg::hm_req_t              mem_req,
    input  lzbw_pkg::byte_t                mem_rdata,
    output lzbw_pkg::core_stat_t           stat
);
    import lzbw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LIT  = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [TOK_W-1:0]     token_reg, token_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LEN_CFG_W-1:0] prod_reg, prod_next;
    win_addr_t            wp_reg, wp_next;
    byte_t                lit_reg, lit_next;
    win_addr_t            src_reg, src_next;
    logic [COPY_W-1:0]    left_reg, left_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 out_valid_reg;
    byte_t                out_byte_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;

    // Token parse of an incoming byte
    logic                      in_acc;
    logic [TOK_W-1:0]          tok_eff;
    logic [CNT_W-1:0]          cnt_eff;
    logic [CNT_W-1:0]          cnt_m1;
    logic [LEN_CFG_W-1:0]      prod_eff;
    logic                      first_bit;
    logic [CNT_W-1:0]          need;
    logic [CNT_W-1:0]          missing;
    logic                      completes;
    logic [CNT_W-1:0]          shamt;
    logic [SH_W-1:0]           rest_sh;
    logic [TOK_W+BYTE_W-1:0]   cat;
    logic [TOK_W-1:0]          full;
    logic [TOK_W-1:0]          rest_tok;
    logic                      fin0;

    // Emission
    logic                 emit_ok;
    logic                 emit_lit;
    logic                 emit_cp;
    logic                 emit;
    byte_t                emit_byte;
    logic [LEN_CFG_W-1:0] prod_inc;
    logic                 fin_now;
    logic                 last_now;

    assign in_acc   = comp_bytes.valid && comp_bytes.ready;
    assign tok_eff  = comp_bytes.stream_start ? '0 : token_reg;
    assign cnt_eff  = comp_bytes.stream_start ? '0 : cnt_reg;
    assign prod_eff = comp_bytes.stream_start ? '0 : prod_reg;
    assign cnt_m1   = cnt_eff - CNT_W'(1);

    assign first_bit = (cnt_eff == '0) ? comp_bytes.data_byte[BYTE_W-1] : tok_eff[cnt_m1];
    assign need      = first_bit ? CNT_W'(LIT_BITS) : CNT_W'(MATCH_BITS);
    assign missing   = need - cnt_eff;
    assign completes = (missing <= CNT_W'(BYTE_W));
    assign shamt     = CNT_W'(BYTE_W) - missing;
    assign rest_sh   = shamt[SH_W-1:0];
    assign cat       = {tok_eff, comp_bytes.data_byte};
    assign full      = TOK_W'(cat >> rest_sh);
    assign rest_tok  = TOK_W'(comp_bytes.data_byte & ~({BYTE_W{1'b1}} << rest_sh));
    assign fin0      = (prod_eff >= output_length);

    assign emit_ok   = !out_valid_reg || plain_bytes.ready;
    assign emit_lit  = (state_reg == ST_LIT) && emit_ok;
    assign emit_cp   = (state_reg == ST_COPY) && rd_pend_reg && emit_ok;
    assign emit      = emit_lit || emit_cp;
    assign emit_byte = emit_lit ? lit_reg : mem_rdata;
    assign prod_inc  = prod_reg + LEN_CFG_W'(1);
    assign fin_now   = (prod_inc >= output_length);
    assign last_now  = emit_lit || (left_reg == COPY_W'(1)) || fin_now;

    always_comb
    begin
        state_next   = state_reg;
        token_next   = token_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        wp_next      = wp_reg;
        lit_next     = lit_reg;
        src_next     = src_reg;
        left_next    = left_reg;
        rd_pend_next = rd_pend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (comp_bytes.stream_start)
                    begin
                        wp_next   = win_addr_t'(WP_RESET);
                        prod_next = '0;
                    end
                    if (fin0)
                    begin
                        token_next = tok_eff;
                        cnt_next   = cnt_eff;
                    end
                    else if (completes)
                    begin
                        token_next   = rest_tok;
                        cnt_next     = CNT_W'(rest_sh);
                        lit_next     = full[BYTE_W-1:0];
                        src_next     = full[LENGTH_BITS +: WINDOW_BITS];
                        left_next    = COPY_W'(full[LENGTH_BITS-1:0]) + COPY_W'(2);
                        rd_pend_next = 1'b0;
                        state_next   = first_bit ? ST_LIT : ST_COPY;
                    end
                    else
                    begin
                        token_next = cat[TOK_W-1:0];
                        cnt_next   = cnt_eff + CNT_W'(BYTE_W);
                    end
                end
            end
            ST_LIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                    src_next     = src_reg + win_addr_t'(1);
                end
                else if (emit_ok)
                begin
                    left_next = left_reg - COPY_W'(1);
                    if (last_now)
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        src_next = src_reg + win_addr_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            wp_next   = wp_reg + win_addr_t'(1);
            prod_next = prod_inc;
            if (fin_now)
            begin
                // drop the rest of the byte
                token_next = '0;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            token_reg     <= '0;
            cnt_reg       <= '0;
            prod_reg      <= '0;
            wp_reg        <= win_addr_t'(WP_RESET);
            left_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            token_reg   <= token_next;
            cnt_reg     <= cnt_next;
            prod_reg    <= prod_next;
            wp_reg      <= wp_next;
            left_reg    <= left_next;
            rd_pend_reg <= rd_pend_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (plain_bytes.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg <= lit_next;
        src_reg <= src_next;
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= last_now;
            out_done_reg <= fin_now;
        end
    end

    always_comb
    begin
        mem_req       = '0;
        mem_req.clear = in_acc && comp_bytes.stream_start;
        mem_req.we    = emit;
        mem_req.waddr = wp_reg;
        mem_req.wdata = emit_byte;
        mem_req.re    = (state_reg == ST_COPY) && (!rd_pend_reg || (emit_cp && !last_now));
        mem_req.raddr = src_reg;
    end

    assign comp_bytes.ready        = (state_reg == ST_IDLE);
    assign plain_bytes.valid       = out_valid_reg;
    assign plain_bytes.out_byte    = out_byte_reg;
    assign plain_bytes.last_of_run = out_last_reg;
    assign plain_bytes.stream_done = out_done_reg;

    assign stat.copying   = (state_reg == ST_COPY);
    assign stat.copy_left = left_reg;

endmodule

`default_nettype wire

// ===== rtl/lzss_byte_window_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel       Role  Payload                                 Request moves
// comp_bytes    sink  data_byte[7:0], stream_start            one compressed byte
// plain_bytes   src   out_byte[7:0], last_of_run, stream_done one decompressed byte
// cfg           sink  output_length[23:0]                     one length write
//
// Steps: a match token is accepted, its first window byte is read, then one byte
// per cycle is emitted while the output register is not stalled.
// Reset: rst_n clears control, the length register and the window written
// marks, so the window reads as zero at once, with no clearing pass.
// Stalls: the output register holds a byte until taken; a copy freezes while
// it is blocked, and compressed bytes are taken only between tokens' output.

module lzss_byte_window_decoder_top (
    input logic         clk,
    input logic         rst_n,
    lzbw_in_if.sink     comp_bytes,
    lzbw_out_if.source  plain_bytes,
    lzbw_cfg_if.sink    cfg
);
    import lzbw_pkg::*;

    logic [LEN_CFG_W-1:0] out_len_reg;
    hm_req_t              mem_req;
    byte_t                mem_rdata;
    core_stat_t           core_stat;

    // Length register; the source must write it only while the decoder is idle (not enforced here)
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            out_len_reg <= cfg.output_length;
        end
    end

    // Token parser, copy sequencer and output register
    lzbw_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .output_length (out_len_reg),
        .comp_bytes    (comp_bytes),
        .plain_bytes   (plain_bytes),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata),
        .stat          (core_stat)
    );

    // History window: one write and one read per cycle, write forwarding
    lzbw_hist_mem u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The finishing byte always closes its run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        plain_bytes.valid && plain_bytes.stream_done |-> plain_bytes.last_of_run)
        else $error("stream_done without last_of_run");

    // Hold off compressed bytes while a copy runs
    a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.copying |-> !comp_bytes.ready)
        else $error("input taken during copy");

    // A running copy always has bytes left
    a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.copying |-> core_stat.copy_left != '0)
        else $error("copy running with no bytes left");

    // The last byte of a copy leaves the copy state
    a_copy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.copying && plain_bytes.ready && mem_req.we &&
        core_stat.copy_left == COPY_W'(1) |=> !core_stat.copying)
        else $error("copy did not end after its last byte");

endmodule

`default_nettype wire
